// ===== rtl/core/lehmer_random_in_range_core_assert.svh =====
// assertion macros used by the checker file
`ifndef LEHMER_RANDOM_IN_RANGE_CORE_ASSERT_SVH
`define LEHMER_RANDOM_IN_RANGE_CORE_ASSERT_SVH

// property checked on every rising edge, skipped while reset is held
`define LRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lrr assertion failed");

// property checked on every rising edge, reset included
`define LRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lrr assertion failed");

`endif

// ===== rtl/core/lrr_pkg.sv =====
`timescale 1ns / 1ps

package lrr_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    // step constants: q = m / a, and a * q + r = m
    localparam logic [16:0] SCH_Q = 17'd127773;
    localparam logic [14:0] LEH_A = 15'd16807;
    localparam logic [30:0] LEH_M = 31'h7FFF_FFFF;

    // floor(2^48 / q), quotient estimate is then exact or one low
    localparam logic [63:0] SCH_RECIP64 = (64'd1 << 48) / 64'd127773;
    localparam logic [31:0] SCH_RECIP   = SCH_RECIP64[31:0];

    localparam int unsigned DIV_STEPS = 32;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);

    // argument count codes, three is taken as two
    localparam logic [1:0] ARGC_NONE = 2'd0;
    localparam logic [1:0] ARGC_ONE  = 2'd1;

    // register index, taken from address bit 2
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic        valid;
        logic [31:0] offset;
        logic [31:0] span;
    } t_job;

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } t_seed_load;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_QUOT,
        BK_CORR,
        BK_STEP,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

// ===== rtl/core/lrr_front.sv =====
`timescale 1ns / 1ps

module lrr_front (
    input  logic          i_valid,
    input  logic          i_full,
    input  logic [1:0]    i_arg_count,
    input  logic [31:0]   i_first_arg,
    input  logic [31:0]   i_second_arg,
    output logic          o_ready,
    output logic          o_push,
    output lrr_pkg::t_job o_job
);
    import lrr_pkg::*;

    logic [31:0] w_offset;
    logic [31:0] w_span;
    logic        w_has_args;

    always_comb begin
        w_has_args = 1'b1;
        w_offset   = 32'd0;
        w_span     = 32'd0;
        case (i_arg_count)
            ARGC_NONE: begin
                w_has_args = 1'b0;
            end
            ARGC_ONE: begin
                w_span = i_first_arg;
            end
            default: begin
                w_offset = i_first_arg;
                w_span   = i_second_arg - i_first_arg;
            end
        endcase
    end

    // a span that is zero or has bit 31 set draws nothing
    assign o_job.valid  = w_has_args && (w_span != 32'd0) && !w_span[31];
    assign o_job.offset = w_offset;
    assign o_job.span   = w_span;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== rtl/core/lrr_queue.sv =====
`timescale 1ns / 1ps

module lrr_queue #(
    parameter int unsigned DEPTH = lrr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lrr_pkg::t_job i_job,
    input  logic          i_pop,
    output lrr_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import lrr_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== rtl/core/lrr_back.sv =====
`timescale 1ns / 1ps

module lrr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrr_pkg::t_seed_load i_seed,
    input  lrr_pkg::t_job       i_job,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic [31:0]         o_m_value,
    output logic                o_m_flag
);
    import lrr_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [31:0]        r_gen;
    logic [31:0]        r_offset;
    logic [31:0]        r_span;
    logic               r_res_valid;
    logic [31:0]        r_abs;
    logic               r_neg;
    logic [15:0]        r_k0;
    logic signed [48:0] r_ax;
    logic [32:0]        r_krem;
    logic signed [16:0] r_k;
    logic [31:0]        r_div;
    logic [31:0]        r_rem;
    logic [4:0]         r_cnt;
    logic               r_m_valid;
    logic [31:0]        r_m_value;
    logic               r_m_flag;

    logic               w_out_load;
    logic [63:0]        w_prod;
    logic [32:0]        w_kq;
    logic [15:0]        w_kmag;
    logic signed [48:0] w_km;
    logic signed [48:0] w_n;
    logic signed [48:0] w_nadj;
    logic [31:0]        w_trial;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_job.valid ? BK_MUL : BK_DONE;
                end
            end
            BK_MUL:  n_state = BK_QUOT;
            BK_QUOT: n_state = BK_CORR;
            BK_CORR: n_state = BK_STEP;
            BK_STEP: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = (r_state == BK_IDLE) && !i_empty;
        w_out_load = (r_state == BK_DONE) && (!r_m_valid || i_m_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // k = trunc(seed / q) from |seed| * floor(2^48/q), then one correction
    assign w_prod = 64'(r_abs) * 64'(SCH_RECIP);
    assign w_kq   = 33'(r_k0) * 33'(SCH_Q);
    assign w_kmag = r_k0 + 16'(r_krem >= 33'(SCH_Q));

    // a*(x - k*q) - r*k is a*x - k*m
    assign w_km   = (49'(r_k) <<< 31) - 49'(r_k);
    assign w_n    = r_ax - w_km;
    assign w_nadj = w_n[48] ? (w_n + 49'(LEH_M)) : w_n;

    // restoring remainder, span stays below 2^31
    assign w_trial = {r_rem[30:0], r_div[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 32'd0;
        end else if (i_seed.load) begin
            r_gen <= i_seed.value;
        end else if (r_state == BK_STEP) begin
            r_gen <= w_nadj[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    r_offset    <= i_job.valid ? i_job.offset : 32'd0;
                    r_span      <= i_job.span;
                    r_res_valid <= i_job.valid;
                    r_rem       <= 32'd0;
                    r_abs       <= r_gen[31] ? (~r_gen + 32'd1) : r_gen;
                    r_neg       <= r_gen[31];
                end
            end
            BK_MUL: begin
                r_k0 <= w_prod[63:48];
                r_ax <= 49'($signed(r_gen)) * 49'($signed({1'b0, LEH_A}));
            end
            BK_QUOT: begin
                r_krem <= 33'(r_abs) - w_kq;
            end
            BK_CORR: begin
                r_k <= r_neg ? -17'(w_kmag) : 17'(w_kmag);
            end
            BK_STEP: begin
                r_div <= w_nadj[31:0];
                r_rem <= 32'd0;
                r_cnt <= '0;
            end
            BK_DIV: begin
                r_rem <= (w_trial >= r_span) ? (w_trial - r_span) : w_trial;
                r_div <= {r_div[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // output register, next draw may start while this word waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_value <= r_offset + r_rem;
            r_m_flag  <= r_res_valid;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_value = r_m_value;
    assign o_m_flag  = r_m_flag;

endmodule

// ===== rtl/core/lehmer_random_in_range_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: first_arg, second_arg; tuser: arg_count
// m_axis    out  tvalid/tready         tdata: rand_value; tuser: rand_valid
// apb       in   psel/penable/pready   seed_value at byte address 0
//
// a draw runs through the queue pop, the quotient estimate (reciprocal
// multiply and correction), the seed update, the bit-serial remainder unit and
// the output load; a request that draws nothing goes from the pop straight to
// the output load. items are handled one at a time by the back end; a two-word
// queue in front takes up to two more words while a draw runs, then drops tready.
// a stalled output word holds the back end in its final cycle. reset is
// synchronous and loads the seed with zero.

module lehmer_random_in_range_core #(
    parameter int unsigned QUEUE_DEPTH = lrr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // first_arg [31:0], second_arg [63:32]
    input  logic [1:0]  i_s_axis_tuser,   // arg_count [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // rand_value [31:0]
    output logic [0:0]  o_m_axis_tuser,   // rand_valid [0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import lrr_pkg::*;

    logic [31:0] r_seed_value;
    t_seed_load  w_seed;
    t_job        w_push_job;
    t_job        w_pop_job;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    logic        w_flag;

    assign o_pready     = 1'b1;
    assign w_seed.load  = i_psel && i_penable && i_pwrite && o_pready
                          && (i_paddr[2] == REG_SEED);
    assign w_seed.value = i_pwdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= 32'd0;
        end else if (w_seed.load) begin
            r_seed_value <= i_pwdata;
        end
    end

    assign o_prdata = r_seed_value;

    lrr_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_full       (w_full),
        .i_arg_count  (i_s_axis_tuser),
        .i_first_arg  (i_s_axis_tdata[31:0]),
        .i_second_arg (i_s_axis_tdata[63:32]),
        .o_ready      (o_s_axis_tready),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    lrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lrr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (w_seed),
        .i_job     (w_pop_job),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_value (o_m_axis_tdata),
        .o_m_flag  (w_flag)
    );

    assign o_m_axis_tuser = w_flag;

endmodule

// ===== rtl/core/lrr_checker.sv =====
`timescale 1ns / 1ps
`include "lehmer_random_in_range_core_assert.svh"

module lrr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] o_prdata,
    input logic        o_pready
);
    import lrr_pkg::*;

    logic w_seed_wr;
    assign w_seed_wr = i_psel && i_penable && i_pwrite && o_pready
                       && (i_paddr[2] == REG_SEED);

    // a stalled word holds
    `LRR_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // an empty draw carries zero
    `LRR_ASSERT(a_empty_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 32'd0)

    // seed readback follows the last write
    `LRR_ASSERT(a_seed_read, i_clk, i_rst_n, w_seed_wr |=> o_prdata == $past(i_pwdata))

    // no word leaves the cycle after reset
    `LRR_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind lehmer_random_in_range_core lrr_checker u_lrr_checker (.*);
